// ----- hdl/keuf_pkg.sv -----
package keuf_pkg;

	// Field widths fixed by the edge and result formats
	localparam int NODE_W   = 11;
	localparam int WEIGHT_W = 52;
	localparam int COST_W   = 64;
	localparam int COUNT_W  = 11;
	localparam int RANK_W   = 4;

	// Default table size
	localparam int NODES_DEF = 2048;

	// Saturation limits
	localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FIND,
		ST_COMP,
		ST_LINK,
		ST_BUMP,
		ST_FINISH
	} keuf_state_t;

endpackage

// ----- hdl/keuf_edge_if.sv -----
interface keuf_edge_if import keuf_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [NODE_W-1:0]   node_a;
	logic [NODE_W-1:0]   node_b;
	logic [WEIGHT_W-1:0] edge_weight;

	modport source (output valid, node_a, node_b, edge_weight, input ready);
	modport sink (input valid, node_a, node_b, edge_weight, output ready);

endinterface

// ----- hdl/keuf_result_if.sv -----
interface keuf_result_if import keuf_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               accepted;
	logic [COST_W-1:0]  total_cost;
	logic [COUNT_W-1:0] accepted_count;

	modport source (output valid, accepted, total_cost, accepted_count, input ready);
	modport sink (input valid, accepted, total_cost, accepted_count, output ready);

endinterface

// ----- hdl/keuf_ram.sv -----
module keuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/kruskal_edge_union_find.sv -----
// Channel   Dir  Payload                                    Transfer
// edges     in   node_a[10:0] node_b[10:0] edge_weight[51:0] valid & ready
// result    out  accepted total_cost[63:0] accepted_count[10:0] valid & ready
//
// One edge at a time through a single parent/rank table RAM (one read and one
// write per cycle, registered read). Each endpoint's path to its root (at most
// log2(NODES) long) is walked and then pointed at the root; the two roots are
// then linked. An endpoint out of range skips the walk and the edge is rejected.
// After reset the table is cleared one entry a cycle with edges.ready low.
// A finished result waits in the output register; the next edge is taken meanwhile
// and its result is held back until the waiting one has been transferred.
module kruskal_edge_union_find import keuf_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	keuf_edge_if.sink      edges,
	keuf_result_if.source  result
);

	localparam int NW = $clog2(NODES);
	localparam int EW = NW + RANK_W;
	localparam logic [NW-1:0] LAST_IDX = NW'(NODES - 1);

	keuf_state_t state_q, state_d;

	logic [NW-1:0]       clr_q;
	logic                side_q;
	logic [NW-1:0]       cur_q;
	logic [NW-1:0]       a_q, b_q;
	logic [NW-1:0]       ra_q, rb_q;
	logic [RANK_W-1:0]   rank_a_q, rank_b_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                ok_q;
	logic [COST_W-1:0]   cost_q;
	logic [COUNT_W-1:0]  count_q;
	logic                out_valid_q;
	logic                out_acc_q;
	logic [COST_W-1:0]   out_cost_q;
	logic [COUNT_W-1:0]  out_cnt_q;

	logic [NW-1:0]     rd_addr, wr_addr;
	logic              wr_en;
	logic [EW-1:0]     wr_data, rd_data;
	logic [NW-1:0]     rd_parent;
	logic [RANK_W-1:0] rd_rank;
	logic [NW-1:0]     cur_root, cur_start;
	logic [NW-1:0]     na_idx, nb_idx;
	logic              in_range, in_fire, out_fire, out_free;
	logic [COST_W:0]   sum_w;

	keuf_ram #(
		.WIDTH (EW),
		.DEPTH (NODES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Table entry fields and per-edge selects
	assign rd_parent = rd_data[RANK_W +: NW];
	assign rd_rank   = rd_data[RANK_W-1:0];
	assign cur_root  = side_q ? rb_q : ra_q;
	assign cur_start = side_q ? b_q : a_q;
	assign na_idx    = NW'(edges.node_a);
	assign nb_idx    = NW'(edges.node_b);
	assign in_range  = (32'(edges.node_a) < 32'(NODES)) && (32'(edges.node_b) < 32'(NODES));

	// Handshakes
	assign edges.ready = (state_q == ST_IDLE);
	assign in_fire     = edges.valid && edges.ready;
	assign out_fire    = out_valid_q && result.ready;
	assign out_free    = !out_valid_q || result.ready;

	// Saturating cost add
	assign sum_w = {1'b0, cost_q} + (COST_W + 1)'(weight_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and table port control
	always_comb begin
		state_d = state_q;
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = {cur_root, rd_rank};
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = {clr_q, {RANK_W{1'b0}}};
				if (clr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr = na_idx;
				if (in_fire) begin
					state_d = in_range ? ST_FIND : ST_FINISH;
				end
			end
			ST_FIND: begin
				if (rd_parent == cur_q) begin
					rd_addr = cur_start;
					state_d = ST_COMP;
				end else begin
					rd_addr = rd_parent;
				end
			end
			ST_COMP: begin
				if (cur_q == cur_root) begin
					rd_addr = b_q;
					state_d = side_q ? ST_LINK : ST_FIND;
				end else begin
					wr_en   = 1'b1;
					rd_addr = rd_parent;
				end
			end
			ST_LINK: begin
				state_d = ST_FINISH;
				if (ra_q != rb_q) begin
					wr_en = 1'b1;
					if (rank_a_q < rank_b_q) begin
						wr_addr = ra_q;
						wr_data = {rb_q, rank_a_q};
					end else begin
						wr_addr = rb_q;
						wr_data = {ra_q, rank_b_q};
						if (rank_a_q == rank_b_q && rank_a_q != RANK_MAX) begin
							state_d = ST_BUMP;
						end
					end
				end
			end
			ST_BUMP: begin
				wr_en   = 1'b1;
				wr_addr = ra_q;
				wr_data = {ra_q, rank_a_q + RANK_W'(1)};
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and running totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			side_q      <= 1'b0;
			ok_q        <= 1'b0;
			cost_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
			if (in_fire) begin
				side_q <= 1'b0;
				ok_q   <= 1'b0;
			end
			if (state_q == ST_COMP && cur_q == cur_root) begin
				side_q <= 1'b1;
			end
			if (state_q == ST_LINK && ra_q != rb_q) begin
				ok_q   <= 1'b1;
				cost_q <= sum_w[COST_W] ? '1 : sum_w[COST_W-1:0];
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
			// a new result replaces one leaving in the same cycle
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk pointer, roots and payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_q      <= na_idx;
			b_q      <= nb_idx;
			cur_q    <= na_idx;
			weight_q <= edges.edge_weight;
		end
		unique case (state_q)
			ST_FIND: begin
				if (rd_parent == cur_q) begin
					cur_q <= cur_start;
					if (side_q) begin
						rb_q     <= cur_q;
						rank_b_q <= rd_rank;
					end else begin
						ra_q     <= cur_q;
						rank_a_q <= rd_rank;
					end
				end else begin
					cur_q <= rd_parent;
				end
			end
			ST_COMP: begin
				cur_q <= (cur_q == cur_root) ? b_q : rd_parent;
			end
			ST_FINISH: begin
				if (out_free) begin
					out_acc_q  <= ok_q;
					out_cost_q <= cost_q;
					out_cnt_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid          = out_valid_q;
	assign result.accepted       = out_acc_q;
	assign result.total_cost     = out_cost_q;
	assign result.accepted_count = out_cnt_q;

endmodule

// ----- hdl/keuf_checker.sv -----
module keuf_checker import keuf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               edges_valid,
	input logic               edges_ready,
	input logic               result_valid,
	input logic               result_ready,
	input logic               result_accepted,
	input logic [COST_W-1:0]  result_total_cost,
	input logic [COUNT_W-1:0] result_accepted_count
);

	logic [COST_W-1:0]  last_cost_q;
	logic [COUNT_W-1:0] last_cnt_q;
	logic [COUNT_W-1:0] next_cnt;

	// Totals shown by the last result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cost_q <= '0;
			last_cnt_q  <= '0;
		end else if (result_valid && result_ready) begin
			last_cost_q <= result_total_cost;
			last_cnt_q  <= result_accepted_count;
		end
	end

	assign next_cnt = (last_cnt_q == COUNT_MAX) ? COUNT_MAX : last_cnt_q + COUNT_W'(1);

	// One edge in work at a time
	a_one_edge: assert property (@(posedge clk) disable iff (!arst_n)
		edges_valid && edges_ready |=> !edges_ready)
		else $error("edge taken while previous edge still in work");

	// Waiting result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_accepted)
			&& $stable(result_total_cost) && $stable(result_accepted_count))
		else $error("result changed while stalled");

	// Rejected edge leaves the totals alone
	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_accepted |->
			result_total_cost == last_cost_q && result_accepted_count == last_cnt_q)
		else $error("totals moved on a rejected edge");

	// Accepted edge steps the count and never lowers the cost
	a_accept_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_accepted |->
			result_accepted_count == next_cnt && result_total_cost >= last_cost_q)
		else $error("totals wrong on an accepted edge");

endmodule

bind kruskal_edge_union_find keuf_checker u_keuf_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.edges_valid           (edges.valid),
	.edges_ready           (edges.ready),
	.result_valid          (result.valid),
	.result_ready          (result.ready),
	.result_accepted       (result.accepted),
	.result_total_cost     (result.total_cost),
	.result_accepted_count (result.accepted_count)
);
